@@ rtl/core/epms_pkg.sv @@
package epms_pkg;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P         = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I         = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D         = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_PERIOD  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_RATE    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_RIGHT  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_COUNT_REVERSED = 3'd6;

  localparam logic signed [23:0] GAIN_P_RESET        = 24'sd3736;
  localparam logic signed [23:0] GAIN_I_RESET        = 24'sd0;
  localparam logic signed [23:0] GAIN_D_RESET        = 24'sd0;
  localparam logic [15:0]        SAMPLE_PERIOD_RESET = 16'd655;
  localparam logic [15:0]        SAMPLE_RATE_RESET   = 16'd100;

  // Item operations
  localparam logic [1:0] OP_EDGE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_ZERO = 2'd2;

  // Command byte
  localparam logic [7:0]  SPEED_MAX       = 8'd255;
  localparam logic [13:0] SPEED_SCALE     = 14'd63;
  localparam int          CMD_CHANNEL_BIT = 7;
  localparam int          CMD_REVERSE_BIT = 6;

  typedef struct packed {
    logic [1:0]         operation;
    logic               phase_b_level;
    logic signed [15:0] setpoint;
  } item_t;

  typedef struct packed {
    logic [7:0]         command_byte;
    logic signed [31:0] measured_rate;
    logic signed [31:0] position_count;
  } result_t;

  // Operand pair fed to the shared multiplier
  typedef enum logic [2:0] {
    MUL_P,
    MUL_IHI,
    MUL_ILO,
    MUL_X,
    MUL_INT,
    MUL_DHI,
    MUL_DLO
  } mul_sel_t;

  // Register update applied in the datapath
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_ERR,
    ACT_ACC_LOAD,
    ACT_ACC_ADD,
    ACT_ACC_ADD_LO,
    ACT_X_LOAD,
    ACT_INC_LOAD,
    ACT_D_LOAD,
    ACT_D_ADD,
    ACT_D_SAT,
    ACT_MAG,
    ACT_FINISH
  } act_t;

  typedef struct packed {
    logic     take;
    mul_sel_t mul_sel;
    act_t     act;
  } dp_cmd_t;

  // m*63/255 for an 8-bit m; exact divide by 255 as (v + (v >> 8) + 1) >> 8
  function automatic logic [5:0] speed_code(input logic [7:0] m);
    logic [13:0] v;
    logic [15:0] t;
    v = 14'(m) * SPEED_SCALE;
    t = 16'(v) + 16'(v >> 8) + 16'd1;
    return t[13:8];
  endfunction

endpackage

@@ rtl/core/epms_ctrl.sv @@
module epms_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic [1:0]        operation,
  output logic              item_ready,
  output logic              result_valid,
  input  logic              result_ready,
  output epms_pkg::dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_MP,
    S_MIH,
    S_MIL,
    S_MX,
    S_XL,
    S_MDH,
    S_MDL,
    S_DADD,
    S_DSAT,
    S_MAG,
    S_OUT
  } state_t;

  state_t state;
  logic   take;
  logic   out_free;

  assign take     = item_valid & item_ready;
  assign out_free = !result_valid || result_ready;

  always_comb begin
    cmd.take    = take;
    cmd.mul_sel = epms_pkg::MUL_P;
    cmd.act     = epms_pkg::ACT_NONE;
    case (state)
      S_ERR:  cmd.act = epms_pkg::ACT_ERR;
      S_MP:   cmd.mul_sel = epms_pkg::MUL_P;
      S_MIH: begin
        cmd.mul_sel = epms_pkg::MUL_IHI;
        cmd.act     = epms_pkg::ACT_ACC_LOAD;
      end
      S_MIL: begin
        cmd.mul_sel = epms_pkg::MUL_ILO;
        cmd.act     = epms_pkg::ACT_ACC_ADD;
      end
      S_MX: begin
        cmd.mul_sel = epms_pkg::MUL_X;
        cmd.act     = epms_pkg::ACT_ACC_ADD_LO;
      end
      S_XL: begin
        cmd.mul_sel = epms_pkg::MUL_INT;
        cmd.act     = epms_pkg::ACT_X_LOAD;
      end
      S_MDH: begin
        cmd.mul_sel = epms_pkg::MUL_DHI;
        cmd.act     = epms_pkg::ACT_INC_LOAD;
      end
      S_MDL: begin
        cmd.mul_sel = epms_pkg::MUL_DLO;
        cmd.act     = epms_pkg::ACT_D_LOAD;
      end
      S_DADD: cmd.act = epms_pkg::ACT_D_ADD;
      S_DSAT: cmd.act = epms_pkg::ACT_D_SAT;
      S_MAG:  cmd.act = epms_pkg::ACT_MAG;
      S_OUT:  cmd.act = out_free ? epms_pkg::ACT_FINISH : epms_pkg::ACT_NONE;
      default: cmd.act = epms_pkg::ACT_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      item_ready   <= 1'b1;
      result_valid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take && operation == epms_pkg::OP_TICK) begin
            state      <= S_ERR;
            item_ready <= 1'b0;
          end
        end
        S_ERR:  state <= S_MP;
        S_MP:   state <= S_MIH;
        S_MIH:  state <= S_MIL;
        S_MIL:  state <= S_MX;
        S_MX:   state <= S_XL;
        S_XL:   state <= S_MDH;
        S_MDH:  state <= S_MDL;
        S_MDL:  state <= S_DADD;
        S_DADD: state <= S_DSAT;
        S_DSAT: state <= S_MAG;
        S_MAG:  state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            item_ready <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state      <= S_IDLE;
          item_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/epms_datapath.sv @@
module epms_datapath #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [epms_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [epms_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  epms_pkg::item_t                     item,
  input  epms_pkg::dp_cmd_t                   cmd,
  output epms_pkg::result_t                   result
);

  localparam int RW = (COUNT_WIDTH > 16 ? COUNT_WIDTH : 16) + 1;

  localparam logic signed [63:0] ERR_HI  = 64'sd2147483647;
  localparam logic signed [63:0] ERR_LO  = -64'sd2147483648;
  localparam logic signed [74:0] D_HI    = 75'sd72057594037927936;
  localparam logic signed [74:0] D_LO    = -75'sd72057594037927936;
  localparam logic signed [49:0] EI_HI   = 50'sd140737488355327;
  localparam logic signed [49:0] EI_LO   = -50'sd140737488355328;
  localparam logic [59:0]        MAG_LIM = 60'(epms_pkg::SPEED_MAX) << 16;

  // Configuration
  logic signed [23:0] gain_p, gain_i, gain_d;
  logic [15:0]        sample_period, sample_rate;
  logic               channel_right, count_reversed;

  // Controller state
  logic [COUNT_WIDTH-1:0] position, last_position, rate;
  logic signed [15:0]     setpoint;
  logic signed [31:0]     err, last_error;
  logic signed [47:0]     error_integral;

  // Work registers
  logic signed [58:0] prod;
  logic signed [59:0] acc;
  logic signed [49:0] xval;
  logic signed [48:0] inc;
  logic signed [74:0] dacc;
  logic [7:0]         speed;
  logic               neg;
  logic               freeze;

  logic signed [24:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [RW-1:0] diff;
  logic signed [63:0]   diff64;
  logic signed [31:0]   err_next;
  logic signed [32:0]   derr;
  logic signed [74:0]   dsat;
  logic signed [59:0]   absv;
  logic signed [49:0]   ei_sum;
  logic signed [47:0]   error_integral_next;
  logic                 up;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= epms_pkg::GAIN_P_RESET;
      gain_i         <= epms_pkg::GAIN_I_RESET;
      gain_d         <= epms_pkg::GAIN_D_RESET;
      sample_period  <= epms_pkg::SAMPLE_PERIOD_RESET;
      sample_rate    <= epms_pkg::SAMPLE_RATE_RESET;
      channel_right  <= 1'b0;
      count_reversed <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        epms_pkg::REG_GAIN_P:         gain_p <= $signed(cfg_data);
        epms_pkg::REG_GAIN_I:         gain_i <= $signed(cfg_data);
        epms_pkg::REG_GAIN_D:         gain_d <= $signed(cfg_data);
        epms_pkg::REG_SAMPLE_PERIOD:  sample_period <= cfg_data[15:0];
        epms_pkg::REG_SAMPLE_RATE:    sample_rate <= cfg_data[15:0];
        epms_pkg::REG_CHANNEL_RIGHT:  channel_right <= cfg_data[0];
        epms_pkg::REG_COUNT_REVERSED: count_reversed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Position counter and tick capture
  assign up = count_reversed ? !item.phase_b_level : item.phase_b_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      last_position <= '0;
    end else if (cmd.take) begin
      case (item.operation)
        epms_pkg::OP_EDGE: begin
          position <= up ? position + COUNT_WIDTH'(1) : position - COUNT_WIDTH'(1);
        end
        epms_pkg::OP_ZERO: begin
          position      <= position - last_position;
          last_position <= '0;
        end
        epms_pkg::OP_TICK: begin
          last_position <= position;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && item.operation == epms_pkg::OP_TICK) begin
      rate     <= position - last_position;
      setpoint <= item.setpoint;
    end
  end

  // Error, saturated to 32 bits
  assign diff   = RW'(setpoint) - RW'($signed(rate));
  assign diff64 = 64'(diff);

  always_comb begin
    if (diff64 > ERR_HI) begin
      err_next = 32'(ERR_HI);
    end else if (diff64 < ERR_LO) begin
      err_next = 32'(ERR_LO);
    end else begin
      err_next = 32'(diff64);
    end
  end

  assign derr = 33'(err) - 33'(last_error);

  // Shared multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      epms_pkg::MUL_P: begin
        mul_a = 25'(gain_p);
        mul_b = 34'(err);
      end
      epms_pkg::MUL_IHI: begin
        mul_a = 25'(gain_i);
        mul_b = 34'($signed(error_integral[47:16]));
      end
      epms_pkg::MUL_ILO: begin
        mul_a = 25'(gain_i);
        mul_b = $signed({18'b0, error_integral[15:0]});
      end
      epms_pkg::MUL_X: begin
        mul_a = $signed({9'b0, sample_rate});
        mul_b = 34'(derr);
      end
      epms_pkg::MUL_INT: begin
        mul_a = $signed({9'b0, sample_period});
        mul_b = 34'(err);
      end
      epms_pkg::MUL_DHI: begin
        mul_a = 25'(gain_d);
        mul_b = 34'($signed(xval[49:25]));
      end
      epms_pkg::MUL_DLO: begin
        mul_a = 25'(gain_d);
        mul_b = $signed({9'b0, xval[24:0]});
      end
      default: begin
        mul_a = 25'(gain_p);
        mul_b = 34'(err);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Derivative term saturates at +-2^56
  always_comb begin
    if (dacc > D_HI) begin
      dsat = D_HI;
    end else if (dacc < D_LO) begin
      dsat = D_LO;
    end else begin
      dsat = dacc;
    end
  end

  assign absv = acc[59] ? -acc : acc;

  assign ei_sum = 50'(error_integral) + 50'(inc);

  always_comb begin
    if (ei_sum > EI_HI) begin
      error_integral_next = 48'(EI_HI);
    end else if (ei_sum < EI_LO) begin
      error_integral_next = 48'(EI_LO);
    end else begin
      error_integral_next = 48'(ei_sum);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.act)
      epms_pkg::ACT_ERR:        err  <= err_next;
      epms_pkg::ACT_ACC_LOAD:   acc  <= 60'(prod);
      epms_pkg::ACT_ACC_ADD:    acc  <= acc + 60'(prod);
      epms_pkg::ACT_ACC_ADD_LO: acc  <= acc + 60'(prod >>> 16);
      epms_pkg::ACT_X_LOAD:     xval <= prod[49:0];
      epms_pkg::ACT_INC_LOAD:   inc  <= prod[48:0];
      epms_pkg::ACT_D_LOAD:     dacc <= 75'(prod) <<< 25;
      epms_pkg::ACT_D_ADD:      dacc <= dacc + 75'(prod);
      epms_pkg::ACT_D_SAT:      acc  <= acc + 60'(dsat);
      epms_pkg::ACT_MAG: begin
        neg    <= acc[59];
        freeze <= $unsigned(absv) > MAG_LIM;
        speed  <= (absv[59:24] != '0) ? epms_pkg::SPEED_MAX : absv[23:16];
      end
      epms_pkg::ACT_FINISH: begin
        result.command_byte[epms_pkg::CMD_CHANNEL_BIT] <= channel_right;
        result.command_byte[epms_pkg::CMD_REVERSE_BIT] <= neg;
        result.command_byte[5:0]  <= epms_pkg::speed_code(speed);
        result.measured_rate      <= 32'($signed(rate));
        result.position_count     <= 32'(position);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error     <= '0;
      error_integral <= '0;
    end else if (cmd.act == epms_pkg::ACT_FINISH) begin
      last_error <= err;
      if (!freeze) begin
        error_integral <= error_integral_next;
      end
    end
  end

endmodule

@@ rtl/core/encoder_pid_motor_speed_core.sv @@
// Throughput: encoder edge and zero items are taken one per cycle, back to back, while
//   item_ready is high; a tick holds item_ready low after its transfer through seven
//   passes through one shared 25x34 multiplier until its result enters the output
//   register, and longer while the previous result still waits there.
// A finished result waits in the output register while new items are taken.
// Reset (rst, synchronous, active high) clears position, integral and derivative
//   history, drops any pending result and loads the register defaults.
module encoder_pid_motor_speed_core #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration writes
  input  logic                              cfg_write,
  input  logic [epms_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [epms_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Item channel
  input  logic                              item_valid,
  output logic                              item_ready,
  input  epms_pkg::item_t                   item,
  // Result channel
  output logic                              result_valid,
  input  logic                              result_ready,
  output epms_pkg::result_t                 result
);

  // Command bundle from the sequencer: transfer strobe, multiplier operand
  // select and the register update to apply this cycle.
  epms_pkg::dp_cmd_t cmd;

  // Sequencer: takes edge and zero items every cycle while idle; on a tick, walks
  // error, P, I (high and low halves), derivative product, integral increment,
  // D (high and low halves), saturated D, magnitude, then hold in the last
  // step until the output register is free and advance the result into it.
  epms_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .operation    (item.operation),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd)
  );

  // Datapath: configuration registers, position counter, shared multiplier
  // with its accumulators, integral state and the result register.
  epms_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .result    (result)
  );

endmodule

@@ rtl/core/epms_checker.sv @@
module epms_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              item_valid,
  input logic                              item_ready,
  input epms_pkg::item_t                   item,
  input logic                              result_valid,
  input logic                              result_ready,
  input epms_pkg::result_t                 result
);

  // A stalled result holds its value
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // A tick transfer closes the input while the controller runs
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.operation == epms_pkg::OP_TICK |=> !item_ready)
    else $error("input still open after tick transfer");

  // Edge, zero and unused items keep the input open
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.operation != epms_pkg::OP_TICK |=> item_ready)
    else $error("input closed after non-tick transfer");

  // A new result appears together with the input reopening
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $rose(item_ready))
    else $error("result raised outside tick completion");

endmodule

bind encoder_pid_motor_speed_core epms_checker u_checker (.*);
